// ===== hw/rtl/dsd_pkg.sv =====
// shared types, constants and functions of the decimal display sequencer
`default_nettype none

package dsd_pkg;

  localparam int VALUE_W        = 14;
  localparam int CNT_W          = 3;
  localparam int POS_W          = 2;
  localparam int BRIGHT_W       = 4;
  localparam int BYTE_W         = 8;
  localparam int MAX_SENT       = 4;
  localparam int DEF_NUM_DIGITS = 4;
  localparam int MAX_VALUE      = (1 << VALUE_W) - 1;

  localparam logic [BYTE_W-1:0] CMD_DATA = 8'h40;
  localparam logic [BYTE_W-1:0] CMD_ADDR = 8'hC0;
  localparam logic [BYTE_W-1:0] CMD_DISP = 8'h80;
  localparam logic [BYTE_W-1:0] SEG_BLANK = 8'h00;

  // floor(n / 10) == (n * 52429) >> 19 for every 14-bit n
  localparam int DIV10_W = 16;
  localparam int DIV10_SH = 19;
  localparam logic [DIV10_W-1:0] DIV10_MUL = 16'd52429;

  typedef struct packed {
    logic [MAX_SENT-1:0][BYTE_W-1:0] codes;  // least significant digit at index 0
    logic [CNT_W-1:0]                count;
    logic [POS_W-1:0]                pos;
  } rec_t;

  function automatic int dec_limit(input int digits);
    int v;
    v = 1;
    for (int i = 0; i < digits; i++) begin
      v = v * 10;
    end
    return v - 1;
  endfunction

  function automatic logic [BYTE_W-1:0] seg_code(input logic [3:0] d);
    logic [BYTE_W-1:0] c;
    case (d)
      4'd0: c = 8'h3F;
      4'd1: c = 8'h06;
      4'd2: c = 8'h5B;
      4'd3: c = 8'h4F;
      4'd4: c = 8'h66;
      4'd5: c = 8'h6D;
      4'd6: c = 8'h7D;
      4'd7: c = 8'h07;
      4'd8: c = 8'h7F;
      4'd9: c = 8'h6F;
      default: c = SEG_BLANK;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dsd_if.sv =====
// request and byte channel interfaces of the decimal display sequencer
`default_nettype none

interface dsd_in_if;
  import dsd_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               show_leading_zeros;
  logic [CNT_W-1:0]   digit_count;
  logic [POS_W-1:0]   start_position;

  modport source (output valid, value, show_leading_zeros, digit_count, start_position,
                  input ready);
  modport sink (input valid, value, show_leading_zeros, digit_count, start_position,
                output ready);
endinterface

interface dsd_out_if;
  import dsd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] bus_byte;
  logic              start_before;
  logic              stop_after;
  logic              last_of_run;

  modport source (output valid, bus_byte, start_before, stop_after, last_of_run,
                  input ready);
  modport sink (input valid, bus_byte, start_before, stop_after, last_of_run,
                output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dsd_front.sv =====
// front end: saturates the request and splits it into segment codes, one digit a stage
`default_nettype none

module dsd_front import dsd_pkg::*; #(
  parameter int NUM_DIGITS = DEF_NUM_DIGITS
) (
  input  logic   clk,
  input  logic   rst,
  dsd_in_if.sink in_ch,
  output logic   push_valid,
  input  logic   push_ready,
  output rec_t   push_rec
);

  localparam int SENT = (NUM_DIGITS < MAX_SENT) ? NUM_DIGITS : MAX_SENT;
  localparam int LIMIT = dec_limit(NUM_DIGITS);
  localparam int SAT = (LIMIT > MAX_VALUE) ? MAX_VALUE : LIMIT;
  localparam logic [VALUE_W-1:0] SAT_V = VALUE_W'(SAT);
  localparam logic [CNT_W-1:0] SENT_C = CNT_W'(SENT);
  localparam int PROD_W = VALUE_W + DIV10_W;

  logic               st_v   [0:SENT];
  logic [VALUE_W-1:0] st_n   [0:SENT];
  logic               st_z   [0:SENT];
  rec_t               st_rec [0:SENT];
  logic               adv;

  assign adv         = !st_v[SENT] || push_ready;
  assign in_ch.ready = adv;
  assign push_valid  = st_v[SENT];
  assign push_rec    = st_rec[SENT];

  // entry stage: clamp value and digit count
  always_ff @(posedge clk) begin
    if (rst) begin
      st_v[0] <= 1'b0;
    end else if (adv) begin
      st_v[0] <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_n[0]            <= (in_ch.value > SAT_V) ? SAT_V : in_ch.value;
      st_z[0]            <= in_ch.show_leading_zeros;
      st_rec[0].codes    <= '0;
      st_rec[0].count    <= (in_ch.digit_count > SENT_C) ? SENT_C : in_ch.digit_count;
      st_rec[0].pos      <= in_ch.start_position;
    end
  end

  for (genvar s = 1; s <= SENT; s++) begin : g_stage
    localparam bit FIRST = (s == 1);
    logic [PROD_W-1:0]  prod;
    logic [VALUE_W-1:0] quo;
    logic [VALUE_W-1:0] rem;
    logic               blank;
    logic [BYTE_W-1:0]  code;
    rec_t               rec_next;

    assign prod  = PROD_W'(st_n[s-1]) * PROD_W'(DIV10_MUL);
    assign quo   = VALUE_W'(prod >> DIV10_SH);
    assign rem   = st_n[s-1] - (quo << 3) - (quo << 1);
    // a digit is a leading zero when it and everything above it is zero
    assign blank = !st_z[s-1] && !FIRST && (st_n[s-1] == '0);
    assign code  = blank ? SEG_BLANK : seg_code(rem[3:0]);

    always_comb begin
      rec_next            = st_rec[s-1];
      rec_next.codes[s-1] = code;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[s] <= 1'b0;
      end else if (adv) begin
        st_v[s] <= st_v[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_n[s]   <= quo;
        st_z[s]   <= st_z[s-1];
        st_rec[s] <= rec_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dsd_queue.sv =====
// two-entry queue between the digit front end and the byte sequencer
`default_nettype none

module dsd_queue import dsd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  rec_t push_rec,
  output logic head_valid,
  output rec_t head_rec,
  input  logic pop
);

  rec_t       mem [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (fill != 2'd2);
  assign head_valid = (fill != 2'd0);
  assign head_rec   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dsd_back.sv =====
// back end: walks one request through its command and segment bytes
`default_nettype none

module dsd_back import dsd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  rec_t                head_rec,
  output logic                pop,
  input  logic                wr_en,
  input  logic [BRIGHT_W-1:0] wr_data,
  dsd_out_if.source           out_ch
);

  logic [BRIGHT_W-1:0] brightness;
  logic [CNT_W-1:0]    step;
  logic [CNT_W-1:0]    last_step;
  logic [1:0]          dig_idx;
  logic                load;
  logic [BYTE_W-1:0]   byte_next;
  logic                start_next;
  logic                stop_next;
  logic                last_next;

  logic                valid;
  logic [BYTE_W-1:0]   bus_byte;
  logic                start_before;
  logic                stop_after;
  logic                last_of_run;

  assign last_step = head_rec.count + CNT_W'(2);
  assign dig_idx   = 2'(head_rec.count + CNT_W'(1) - step);
  assign load      = head_valid && (!valid || out_ch.ready);
  assign pop       = load && (step == last_step);

  always_comb begin
    last_next  = (step == last_step);
    start_next = (step == '0) || (step == CNT_W'(1)) || last_next;
    stop_next  = (step == '0) || (step == head_rec.count + CNT_W'(1)) || last_next;
    if (step == '0) begin
      byte_next = CMD_DATA;
    end else if (step == CNT_W'(1)) begin
      byte_next = CMD_ADDR + BYTE_W'(head_rec.pos);
    end else if (last_next) begin
      byte_next = CMD_DISP + BYTE_W'(brightness);
    end else begin
      byte_next = head_rec.codes[dig_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= '0;
    end else if (wr_en) begin
      brightness <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step  <= '0;
      valid <= 1'b0;
    end else begin
      if (load) begin
        valid <= 1'b1;
        step  <= last_next ? '0 : step + CNT_W'(1);
      end else if (out_ch.ready) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bus_byte     <= byte_next;
      start_before <= start_next;
      stop_after   <= stop_next;
      last_of_run  <= last_next;
    end
  end

  assign out_ch.valid        = valid;
  assign out_ch.bus_byte     = bus_byte;
  assign out_ch.start_before = start_before;
  assign out_ch.stop_after   = stop_after;
  assign out_ch.last_of_run  = last_of_run;

endmodule

`default_nettype wire

// ===== hw/rtl/decimal_seven_segment_display.sv =====
// top level of the decimal seven-segment display command sequencer
//
//   channel   dir  handshake         payload
//   in_ch     in   valid / ready     value, show_leading_zeros, digit_count, start_position
//   out_ch    out  valid / ready     bus_byte, start_before, stop_after, last_of_run
//   wr_en     in   write enable      wr_data (brightness level)
//
// one byte leaves per cycle while out_ch is ready, 3 + digit_count bytes per request,
// digit_count clamped to min(NUM_DIGITS, 4); a request holds the byte sequencer until
// its last byte; the digit pipeline takes a request every cycle unless the queue is full
// rst is synchronous and clears all valid flags and the brightness register
// a stall on out_ch backs up through the two-entry queue into the front end
`default_nettype none

module decimal_seven_segment_display import dsd_pkg::*; #(
  parameter int NUM_DIGITS = DEF_NUM_DIGITS
) (
  input  logic                clk,
  input  logic                rst,
  dsd_in_if.sink              in_ch,
  dsd_out_if.source           out_ch,
  input  logic                wr_en,
  input  logic [BRIGHT_W-1:0] wr_data
);

  logic push_valid;
  logic push_ready;
  rec_t push_rec;
  logic head_valid;
  rec_t head_rec;
  logic pop;

  dsd_front #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec)
  );

  dsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (pop)
  );

  dsd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (pop),
    .wr_en      (wr_en),
    .wr_data    (wr_data),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/dsd_checker.sv =====
// port-level checks on the byte channel of the display sequencer
`default_nettype none

module dsd_checker import dsd_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] bus_byte,
  input logic              start_before,
  input logic              stop_after,
  input logic              last_of_run
);

  // byte held until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("byte dropped before it was taken");

  // stalled byte keeps its contents
  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(bus_byte) && $stable(last_of_run))
    else $error("stalled byte changed");

  // closing byte is a framed display command
  a_close: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_run |-> start_before && stop_after && (bus_byte[7:4] == 4'h8))
    else $error("closing byte is not a framed display command");

  // a new run opens with the framed data command
  a_open: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_of_run |=>
      !out_valid || (start_before && stop_after && (bus_byte == CMD_DATA)))
    else $error("run does not open with the data command");

endmodule

bind decimal_seven_segment_display dsd_checker u_dsd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .bus_byte     (out_ch.bus_byte),
  .start_before (out_ch.start_before),
  .stop_after   (out_ch.stop_after),
  .last_of_run  (out_ch.last_of_run)
);

`default_nettype wire
